// File: hdl/assert_macros.svh
// assertion helpers, sampled on the rising clock edge and off during reset
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every edge
`define ASSERT_CLK(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// condition must never be seen
`define ASSERT_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// File: hdl/psu_pkg.sv
`timescale 1ns / 1ps

package psu_pkg;

    localparam int unsigned WORD_BITS_DEF = 32;
    localparam int unsigned IN_W          = 32;
    localparam int unsigned SAMPLE_W      = 32;
    localparam int unsigned BPS_W         = 6;
    localparam int unsigned SPL_W         = 16;
    localparam int unsigned CFG_IDX_W     = 2;
    localparam int unsigned CFG_DATA_W    = 32;
    localparam int unsigned MAX_TAKE      = 32;
    localparam int unsigned CNT_W         = $clog2(MAX_TAKE);

    localparam logic [BPS_W-1:0] BPS_RST = BPS_W'(10);
    localparam logic             PAD_RST = 1'b0;
    localparam logic [SPL_W-1:0] SPL_RST = SPL_W'(3);

    localparam logic [CFG_IDX_W-1:0] CFG_BPS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PAD = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SPL = 2'd2;

    typedef enum logic {
        ST_IDLE,
        ST_RUN
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic step;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic bad_bps;
        logic last;
        logic slot_free;
    } sts_t;

endpackage

// File: hdl/psu_cfg.sv
`timescale 1ns / 1ps

module psu_cfg
    import psu_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_valid,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output logic [BPS_W-1:0]      bps,
    output logic                  pad_mode,
    output logic [SPL_W-1:0]      spl
);

    logic [BPS_W-1:0] bps_reg;
    logic             pad_reg;
    logic [SPL_W-1:0] spl_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bps_reg <= BPS_RST;
            pad_reg <= PAD_RST;
            spl_reg <= SPL_RST;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_BPS: bps_reg <= cfg_data[BPS_W-1:0];
                CFG_PAD: pad_reg <= cfg_data[0];
                CFG_SPL: spl_reg <= cfg_data[SPL_W-1:0];
                default: ;
            endcase
        end
    end

    assign bps      = bps_reg;
    assign pad_mode = pad_reg;
    assign spl      = spl_reg;

endmodule

// File: hdl/psu_ctrl.sv
`timescale 1ns / 1ps

module psu_ctrl
    import psu_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_ready,
    input  sts_t sts,
    output cmd_t cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                // a word with an unusable sample width is dropped right away
                if (in_valid && !sts.bad_bps)
                begin
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                if (sts.slot_free && sts.last)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        in_ready = 1'b0;
        cmd      = '0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load = in_valid;
            end
            ST_RUN:
            begin
                cmd.step = sts.slot_free;
            end
            default: ;
        endcase
    end

    `include "assert_macros.svh"

    `ASSERT_CLK(a_last_returns_idle, cmd.step && sts.last |=> in_ready, "last sample did not free input")
    `ASSERT_NEVER(a_step_while_ready, cmd.step && in_ready, "sample emitted while taking a word")

endmodule

// File: hdl/psu_dp.sv
`timescale 1ns / 1ps

module psu_dp
    import psu_pkg::*;
#(
    parameter int unsigned WORD_BITS = WORD_BITS_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  cmd_t                cmd,
    output sts_t                sts,
    input  logic [BPS_W-1:0]    bps,
    input  logic                pad_mode,
    input  logic [SPL_W-1:0]    spl,
    input  logic [IN_W-1:0]     packed_word,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [SAMPLE_W-1:0] sample,
    output logic                word_done,
    output logic                line_end
);

    localparam int unsigned AvailW = $clog2(WORD_BITS + 1);
    localparam int unsigned AW     = (AvailW > BPS_W) ? AvailW : BPS_W + 1;
    localparam int unsigned BpsN   = 2 ** BPS_W;

    // top padding bits for every sample width, worked out at elaboration
    logic [AW-1:0] pad_tab [BpsN];

    assign pad_tab[0] = '0;
    for (genvar g = 1; g < BpsN; g++)
    begin : g_pad
        localparam int unsigned PadG = WORD_BITS % g;
        assign pad_tab[g] = AW'(PadG);
    end

    logic [WORD_BITS-1:0] word_reg, word_next;
    logic [AW-1:0]        avail_reg, avail_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic [SPL_W-1:0]     pos_reg, pos_next;
    logic                 out_valid_reg, out_valid_next;
    logic [SAMPLE_W-1:0]  sample_reg, sample_next;
    logic                 word_done_reg, word_done_next;
    logic                 line_end_reg, line_end_next;

    logic [AW-1:0]        bps_ext;
    logic [AW-1:0]        shift;
    logic [WORD_BITS-1:0] smask;
    logic [WORD_BITS-1:0] field;
    logic [SPL_W:0]       line_len;
    logic [SPL_W:0]       pos_inc;
    logic                 line_last;
    logic                 bits_last;
    logic                 cnt_last;
    logic                 last;

    assign bps_ext   = AW'(bps);
    assign shift     = avail_reg - bps_ext;
    assign smask     = ~({WORD_BITS{1'b1}} << bps);
    assign field     = (word_reg >> shift) & smask;

    // zero line length means a full 16-bit count
    assign line_len  = (spl == '0) ? {1'b1, {SPL_W{1'b0}}} : {1'b0, spl};
    assign pos_inc   = {1'b0, pos_reg} + (SPL_W + 1)'(1);
    assign line_last = pos_inc >= line_len;
    assign bits_last = shift < bps_ext;
    assign cnt_last  = cnt_reg == CNT_W'(MAX_TAKE - 1);
    assign last      = bits_last || cnt_last || line_last;

    assign sts.bad_bps   = (bps == '0) || (bps_ext > AW'(WORD_BITS));
    assign sts.last      = last;
    assign sts.slot_free = !out_valid_reg || out_ready;

    always_comb
    begin
        word_next      = word_reg;
        avail_next     = avail_reg;
        cnt_next       = cnt_reg;
        pos_next       = pos_reg;
        out_valid_next = out_valid_reg;
        sample_next    = sample_reg;
        word_done_next = word_done_reg;
        line_end_next  = line_end_reg;

        if (out_ready)
        begin
            out_valid_next = 1'b0;
        end

        if (cmd.load)
        begin
            word_next  = WORD_BITS'(packed_word);
            avail_next = AW'(WORD_BITS) - (pad_mode ? pad_tab[bps] : '0);
            cnt_next   = '0;
        end

        if (cmd.step)
        begin
            avail_next     = shift;
            cnt_next       = cnt_reg + CNT_W'(1);
            pos_next       = line_last ? '0 : pos_inc[SPL_W-1:0];
            out_valid_next = 1'b1;
            sample_next    = SAMPLE_W'(field);
            word_done_next = last;
            line_end_next  = line_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pos_reg       <= pos_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        word_reg      <= word_next;
        avail_reg     <= avail_next;
        cnt_reg       <= cnt_next;
        sample_reg    <= sample_next;
        word_done_reg <= word_done_next;
        line_end_reg  <= line_end_next;
    end

    assign out_valid = out_valid_reg;
    assign sample    = sample_reg;
    assign word_done = word_done_reg;
    assign line_end  = line_end_reg;

    `include "assert_macros.svh"

    `ASSERT_CLK(a_no_underflow, cmd.step |-> (avail_reg >= bps_ext), "sample read past word bottom")
    `ASSERT_CLK(a_line_end_word, out_valid_reg && line_end_reg |-> word_done_reg, "line end without word done")

endmodule

// File: hdl/packed_sample_unpacker_unit.sv
`timescale 1ns / 1ps

// channel  direction  payload                         handshake
// in       input      packed_word                     in_valid / in_ready
// out      output     sample, word_done, line_end     out_valid / out_ready
// cfg      input      cfg_index, cfg_data             cfg_valid / cfg_ready
//
// a word is taken while idle, then one sample leaves per cycle unless the output stalls;
// a word yields n samples, n = min(floor(WORD_BITS / bits_per_sample), 32, rest of line),
// three samples for 10-bit samples in a 32-bit word; the single sample extractor sets the rate
// a word with zero or oversized sample width is taken and dropped without any sample
// rst_n clears line position, output valid and the controller state
// a stalled output holds the extractor; the next word waits in the input

module packed_sample_unpacker_unit
    import psu_pkg::*;
#(
    parameter int unsigned WORD_BITS = WORD_BITS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [IN_W-1:0]       packed_word,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [SAMPLE_W-1:0]   sample,
    output logic                  word_done,
    output logic                  line_end,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    logic [BPS_W-1:0] bps;
    logic             pad_mode;
    logic [SPL_W-1:0] spl;
    cmd_t             cmd;
    sts_t             sts;

    assign cfg_ready = 1'b1;

    psu_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .bps       (bps),
        .pad_mode  (pad_mode),
        .spl       (spl)
    );

    psu_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    psu_dp #(
        .WORD_BITS (WORD_BITS)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .sts         (sts),
        .bps         (bps),
        .pad_mode    (pad_mode),
        .spl         (spl),
        .packed_word (packed_word),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .sample      (sample),
        .word_done   (word_done),
        .line_end    (line_end)
    );

endmodule

// File: bench/sample_stream_checker.sv
`timescale 1ns / 1ps

module sample_stream_checker
    import psu_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    input  logic                  in_ready,
    input  logic [IN_W-1:0]       packed_word,
    input  logic                  out_valid,
    input  logic                  out_ready,
    input  logic [SAMPLE_W-1:0]   sample,
    input  logic                  word_done,
    input  logic                  line_end,
    input  logic                  cfg_valid,
    input  logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output int                    errors,
    output int                    pending
);

    typedef struct packed {
        logic [SAMPLE_W-1:0] value;
        logic                word_done;
        logic                line_end;
    } sample_rec_t;

    sample_rec_t      expected_samples[$];
    logic [BPS_W-1:0] bps;
    logic             pad_mode;
    logic [SPL_W-1:0] spl;
    logic [SPL_W-1:0] line_pos;

    // works out the samples one packed word yields and advances the line position
    function automatic void unpack_word(input logic [IN_W-1:0] word);
        int unsigned per_word;
        int unsigned pad;
        int unsigned line_len;
        int unsigned remaining;
        int unsigned take;
        int unsigned shift;
        int unsigned k;
        logic [63:0] smask;
        logic [63:0] wide_word;
        sample_rec_t rec;
        if (bps == 0 || bps > WORD_BITS_DEF)
            return;
        per_word = WORD_BITS_DEF / bps;
        pad = pad_mode ? (WORD_BITS_DEF % bps) : 0;
        line_len = (spl == 0) ? 65536 : spl;
        // a line shortened below the current position ends on the next sample
        remaining = (line_pos < line_len) ? (line_len - line_pos) : 1;
        take = per_word;
        if (take > MAX_TAKE)
            take = MAX_TAKE;
        if (take > remaining)
            take = remaining;
        smask = (64'd1 << bps) - 64'd1;
        wide_word = {32'd0, word};
        for (k = 0; k < take; k++)
        begin
            shift = WORD_BITS_DEF - pad - (k + 1) * bps;
            rec.value = SAMPLE_W'((wide_word >> shift) & smask);
            rec.word_done = (k + 1 == take);
            rec.line_end = (k + 1 == remaining);
            expected_samples.push_back(rec);
        end
        if (take == remaining)
            line_pos = '0;
        else
            line_pos = SPL_W'(line_pos + take);
    endfunction

    function automatic void check_field(input string field, input logic [31:0] want,
                                        input logic [31:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
            errors = errors + 1;
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        sample_rec_t head;
        if (!rst_n)
        begin
            bps = BPS_RST;
            pad_mode = PAD_RST;
            spl = SPL_RST;
            line_pos = '0;
            errors = 0;
            expected_samples.delete();
            pending <= 0;
        end
        else
        begin
            // results leaving now belong to words taken earlier, so pop before push
            if (out_valid && out_ready)
            begin
                if (expected_samples.size() == 0)
                begin
                    $display("%0t: unexpected transaction, expected none, actual sample %h",
                             $time, sample);
                    errors = errors + 1;
                end
                else
                begin
                    head = expected_samples.pop_front();
                    check_field("sample", head.value, sample);
                    check_field("word_done", 32'(head.word_done), 32'(word_done));
                    check_field("line_end", 32'(head.line_end), 32'(line_end));
                end
            end
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_BPS: bps = cfg_data[BPS_W-1:0];
                    CFG_PAD: pad_mode = cfg_data[0];
                    CFG_SPL: spl = cfg_data[SPL_W-1:0];
                    default: ;
                endcase
            end
            if (in_valid && in_ready)
                unpack_word(packed_word);
            pending <= expected_samples.size();
        end
    end

endmodule

// File: bench/packed_sample_unpacker_unit_test.sv
`timescale 1ns / 1ps

module packed_sample_unpacker_unit_test
    import psu_pkg::*;
();

    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
    localparam int RX_HOLD_CYCLES = 300;
    localparam int DRAIN_CYCLES = 12;
    localparam int PHASES = 8;
    localparam int ITEMS_PER_PHASE = 17;
    localparam int PHASE_BPS [PHASES] = '{10, 1, 32, 7, 12, 5, 3, 16};
    localparam int PHASE_PAD [PHASES] = '{0, 1, 1, 1, 0, 1, 1, 0};
    localparam int PHASE_SPL [PHASES] = '{3, 0, 1, 9, 65535, 4, 11, 2};

    logic                  clk;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_ready;
    logic [IN_W-1:0]       packed_word;
    logic                  out_valid;
    logic                  out_ready;
    logic [SAMPLE_W-1:0]   sample;
    logic                  word_done;
    logic                  line_end;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    int                    errors;
    int                    pending;

    int tx_idle_pct = 24;
    int rx_idle_pct = 67;
    bit rx_hold_req = 1'b0;

    packed_sample_unpacker_unit DUT (.*);

    sample_stream_checker checker_inst (.*);

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #1ms;
        $display("packed_sample_unpacker_unit test failed");
        $finish;
    end

    // receiver side, with one long hold-off
    initial
    begin
        out_ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rx_hold_req)
            begin
                rx_hold_req = 1'b0;
                out_ready <= 1'b0;
                repeat (RX_HOLD_CYCLES) @(posedge clk);
            end
            out_ready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    task automatic send_word(input logic [IN_W-1:0] word);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        packed_word <= word;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    // upper data bits outside the register are random filler
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value,
                             input logic [CFG_DATA_W-1:0] field_mask);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= ($urandom & ~field_mask) | (value & field_mask);
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
    endtask

    task automatic set_config(input int bps, input int pad, input int spl);
        write_reg(CFG_BPS, bps, 32'h3f);
        write_reg(CFG_PAD, pad, 32'h1);
        write_reg(CFG_SPL, spl, 32'hffff);
        cfg_valid <= 1'b0;
    endtask

    // stop offering words until every expected sample is out
    task automatic wait_idle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    function automatic logic [IN_W-1:0] random_word();
        case ($urandom_range(9))
            0: random_word = '0;
            1: random_word = '1;
            default: random_word = $urandom;
        endcase
    endfunction

    initial
    begin
        rst_n = 1'b0;
        in_valid <= 1'b0;
        packed_word <= '0;
        cfg_valid <= 1'b0;
        cfg_index <= CFG_BPS;
        cfg_data <= '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: 10-bit samples, three to a line
        send_word(32'h0000_0000);
        send_word(32'hffff_ffff);
        send_word(32'h1234_5678);
        wait_idle();

        // one-bit samples, then a line shortened below the current position
        set_config(1, 0, 100);
        send_word(32'haaaa_aaaa);
        wait_idle();
        set_config(1, 0, 5);
        send_word(32'h8000_0001);
        send_word(32'h5555_5555);
        wait_idle();

        // full-width samples, zero line length taken as 65536
        set_config(32, 1, 0);
        send_word(32'hffff_ffff);
        send_word(32'h0000_0000);
        send_word(32'h8000_0001);
        wait_idle();

        // pad-high with four dropped top bits
        set_config(7, 1, 2);
        send_word(32'hffff_ffff);
        send_word(32'h0fff_ffff);
        send_word(32'hf000_0000);
        wait_idle();

        // zero and oversized sample widths yield nothing
        set_config(0, 0, 3);
        send_word(32'hdead_beef);
        wait_idle();
        set_config(33, 1, 3);
        send_word(32'hffff_ffff);
        wait_idle();
        set_config(63, 0, 65535);
        send_word(32'h0123_4567);
        wait_idle();

        write_reg(CFG_UNUSED, $urandom, '1);
        set_config(31, 1, 7);
        send_word(32'hffff_fffe);
        send_word(32'h7fff_ffff);
        wait_idle();

        for (int p = 0; p < PHASES; p++)
        begin
            if (p == 3)
            begin
                tx_idle_pct = 67;
                rx_idle_pct = 24;
            end
            else if (p == 6)
            begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            set_config(PHASE_BPS[p], PHASE_PAD[p], PHASE_SPL[p]);
            for (int i = 0; i < ITEMS_PER_PHASE; i++)
            begin
                if (p == 1 && i == 2)
                    rx_hold_req = 1'b1;
                if (p == 4 && i == ITEMS_PER_PHASE / 2)
                    wait_idle();
                send_word(random_word());
            end
            wait_idle();
        end

        if (errors == 0)
            $display("packed_sample_unpacker_unit test passed");
        else
            $display("packed_sample_unpacker_unit test failed");
        $finish;
    end

endmodule
